[sv/scancode_to_ascii_fifo_top_defines.svh]
// Assertion macros shared by the checker of the scancode decoder.
// No dependencies.
`ifndef SCANCODE_TO_ASCII_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SCTA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SCTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/scta_pkg.sv]
// Shared types, key codes and keymap tables of the scancode decoder.
// No dependencies.
package scta_pkg;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   localparam logic [6:0] KEY_CTRL   = 7'h1d;
   localparam logic [6:0] KEY_LSHIFT = 7'h2a;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_ALT    = 7'h38;
   localparam logic [6:0] KEY_CAPS   = 7'h3a;
   localparam int         KEY_NUM    = 58;
   localparam logic [6:0] KEY_LIMIT  = 7'(KEY_NUM);

   localparam int FLAG_CTRL  = 0;
   localparam int FLAG_SHIFT = 1;
   localparam int FLAG_ALT   = 2;
   localparam int FLAG_CAPS  = 3;

   typedef logic [3:0] scta_flags_type;

   typedef struct packed {
      logic       wr;
      logic [6:0] ch;
   } scta_push_type;

   localparam logic [7:0] PLAIN_MAP [KEY_NUM] = '{
      8'h00, 8'h00, "1",   "2",   "3",   "4",   "5",   "6",   "7",   "8",   "9",   "0",
      "-",   "=",   8'h08, 8'h09, "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
      "o",   "p",   "[",   "]",   8'h0a, 8'h00, "a",   "s",   "d",   "f",   "g",   "h",
      "j",   "k",   "l",   ";",   "'",   "#",   8'h00, "\\",  "z",   "x",   "c",   "v",
      "b",   "n",   "m",   ",",   ".",   "/",   8'h00, "*",   8'h00, " "
   };

   localparam logic [7:0] SHIFT_MAP [KEY_NUM] = '{
      8'h00, 8'h00, "!",   "\"",  "#",   "$",   "%",   "^",   "&",   "*",   "(",   ")",
      "_",   "+",   8'h08, 8'h09, "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
      "O",   "P",   "{",   "}",   8'h0a, 8'h00, "A",   "S",   "D",   "F",   "G",   "H",
      "J",   "K",   "L",   ":",   "@",   "~",   8'h00, "|",   "Z",   "X",   "C",   "V",
      "B",   "N",   "M",   "<",   ">",   "?",   8'h00, "*",   8'h00, " "
   };

endpackage

[sv/scta_decode.sv]
// Modifier tracking and keymap lookup for one scancode word.
// Depends on scta_pkg.
module scta_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [7:0]             scancode,
   output scta_pkg::scta_push_type push
);
   import scta_pkg::*;

   localparam logic [6:0] CH_LA = 7'h61;
   localparam logic [6:0] CH_LZ = 7'h7a;
   localparam logic [6:0] CH_UA = 7'h41;
   localparam logic [6:0] CH_UZ = 7'h5a;
   localparam logic [6:0] CASE_BIT = 7'h20;

   scta_flags_type flags_ff, flags_in;
   logic           released;
   logic [6:0]     key;
   logic [5:0]     idx;
   logic [7:0]     raw;
   logic [6:0]     ch;
   logic           letter;

   always_comb begin
      released = scancode[7];
      key      = scancode[6:0];
      idx      = key[5:0];
      raw      = flags_ff[FLAG_SHIFT] ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
      letter   = (raw[6:0] >= CH_LA && raw[6:0] <= CH_LZ) ||
                 (raw[6:0] >= CH_UA && raw[6:0] <= CH_UZ);
      ch       = (flags_ff[FLAG_CAPS] && letter) ? (raw[6:0] ^ CASE_BIT) : raw[6:0];
      flags_in = flags_ff;
      push.wr  = 1'b0;
      push.ch  = ch;
      if (en) begin
         case (key) inside
            KEY_CTRL: begin
               flags_in[FLAG_CTRL] = !released;
            end
            KEY_LSHIFT, KEY_RSHIFT: begin
               flags_in[FLAG_SHIFT] = !released;
            end
            KEY_ALT: begin
               flags_in[FLAG_ALT] = !released;
            end
            KEY_CAPS: begin
               if (!released) flags_in[FLAG_CAPS] = !flags_ff[FLAG_CAPS];
            end
            default: begin
               push.wr = !released && !flags_ff[FLAG_CTRL] && !flags_ff[FLAG_ALT] &&
                         (key < KEY_LIMIT) && (ch != 7'd0);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

[sv/scta_fifo.sv]
// Ring buffer of characters with drop-on-full and registered read data.
// Depends on scta_pkg.
module scta_fifo #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  scta_pkg::scta_push_type push,
   input  logic                    poll,
   output logic                    has_data,
   output logic [6:0]              rd_data_ff
);
   import scta_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [6:0]       mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en;
   logic             rd_en;

   always_comb begin
      has_data  = (count_ff != '0);
      wr_en     = push.wr && (count_ff != CNT_FULL);
      rd_en     = poll && has_data;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= push.ch;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_ptr_ff];
   end

endmodule

[sv/scancode_to_ascii_fifo_top.sv]
// Top level of the scancode set 1 decoder with character FIFO.
// Depends on scta_pkg, scta_decode and scta_fifo.
//
// Request channel (req_): each word is a push of one scancode byte
// (req_type = 0) or a poll for the oldest stored character (req_type = 1).
// A push returns nothing; it updates ctrl/shift/alt/caps state and may
// store one character, dropped when the FIFO holds FIFO_DEPTH characters.
// Response channel (rsp_): one word per poll, rsp_got_char = 1 with the
// character, or rsp_got_char = 0 and rsp_ascii_char = 0 when empty.
// A poll's response is registered as the poll leaves the request
// register, and a push is seen by a poll accepted in the very next cycle.
// Throughput: one word per cycle while req_stall is low; keymap lookup
// and FIFO update run between the request and the response register.
// While rsp_stall holds a response, pushes still flow; a poll waiting
// behind the held response raises req_stall until the response is taken.
// Reset clears modifier state, pointers and fill count;
// stored characters are not cleared.
module scancode_to_ascii_fifo_top #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_scancode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_got_char,
   output logic [6:0] rsp_ascii_char
);
   import scta_pkg::*;

   logic          a_valid_ff, a_valid_in;
   logic          a_type_ff;
   logic [7:0]    a_code_ff;
   logic          o_valid_ff, o_valid_in;
   logic          o_got_ff;
   logic          a_blocked;
   logic          a_fire;
   logic          req_take;
   logic          poll_fire;
   logic          has_data;
   logic [6:0]    rd_data_ff;
   scta_push_type push;

   always_comb begin
      a_blocked  = a_valid_ff && (a_type_ff == REQ_POLL) && o_valid_ff && rsp_stall;
      a_fire     = a_valid_ff && !a_blocked;
      poll_fire  = a_fire && (a_type_ff == REQ_POLL);
      req_stall  = a_blocked;
      req_take   = req_valid && !req_stall;
      a_valid_in = req_take ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);
      o_valid_in = poll_fire ? 1'b1 : ((o_valid_ff && !rsp_stall) ? 1'b0 : o_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_type_ff <= req_type;
         a_code_ff <= req_scancode;
      end
      if (poll_fire) o_got_ff <= has_data;
   end

   scta_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .en       (a_fire && (a_type_ff == REQ_PUSH)),
      .scancode (a_code_ff),
      .push     (push)
   );

   scta_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .poll       (poll_fire),
      .has_data   (has_data),
      .rd_data_ff (rd_data_ff)
   );

   assign rsp_valid      = o_valid_ff;
   assign rsp_got_char   = o_got_ff;
   assign rsp_ascii_char = o_got_ff ? rd_data_ff : 7'd0;

endmodule

[sv/scta_checker.sv]
// Port-level checks on the scancode decoder, bound to its top level.
// Depends on scancode_to_ascii_fifo_top_defines.svh.
`include "scancode_to_ascii_fifo_top_defines.svh"

module scta_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_type,
   input logic [7:0] req_scancode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_got_char,
   input logic [6:0] rsp_ascii_char
);

   `SCTA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_got_char) && $stable(rsp_ascii_char), "response word changed while stalled")
   `SCTA_ASSERT(a_empty_zero, clock, reset, rsp_valid && !rsp_got_char |-> rsp_ascii_char == 7'd0, "empty poll returned a nonzero character")
   `SCTA_ASSERT(a_got_nonzero, clock, reset, rsp_valid && rsp_got_char |-> rsp_ascii_char != 7'd0, "stored character read back as zero")
   `SCTA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall, "channels not idle after reset")

endmodule

bind scancode_to_ascii_fifo_top scta_checker u_scta_checker (.*);
